@@ hdl/wms_pkg.sv @@
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and constants of the window maximum suppression block.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_RADIUS_DEF  = 7;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam logic [10:0]        FRAME_WIDTH_RST  = 11'd640;
  localparam logic [15:0]        FRAME_HEIGHT_RST = 16'd480;
  localparam logic [2:0]         RADIUS_RST       = 3'd2;
  localparam logic signed [31:0] SUPPRESS_RST     = -32'sd100;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_RADIUS         = 2'd2,
    REG_SUPPRESS_VALUE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CENTER = 2'd1,
    ST_SCAN   = 2'd2,
    ST_LAST   = 2'd3
  } state_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] response;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [9:0]         out_col;
    logic [15:0]        out_row;
    logic               was_suppressed;
    logic               frame_last;
  } out_item_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic row_en;
    logic is_center;
  } cell_ctl_t;

endpackage

@@ hdl/wms_ram.sv @@
// ----------------------------------------------------------------------------
// wms_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/wms_cell.sv @@
// ----------------------------------------------------------------------------
// wms_cell
// One line of the sample ring: a line bank, a compare against the center
// sample and a link in the suppress and center chains.
// ----------------------------------------------------------------------------
module wms_cell #(
  parameter int SW        = 32,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  wms_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic signed [SW-1:0]         wr_data,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         col_ok,
  input  logic signed [SW-1:0]         center,
  input  logic                         greater_in,
  input  logic signed [SW-1:0]         center_in,
  output logic                         greater_out,
  output logic signed [SW-1:0]         center_out
);

  logic [SW-1:0] rd_data;
  logic          hit;

  wms_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_bank (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign hit         = col_ok && ctl.row_en && ($signed(rd_data) > center);
  assign greater_out = greater_in | hit;
  assign center_out  = ctl.is_center ? $signed(rd_data) : center_in;

endmodule

@@ hdl/window_max_suppression.sv @@
// ----------------------------------------------------------------------------
// window_max_suppression
// Streaming 2-D non-maximum suppression over a clipped square window.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and are written into a ring of
// 2*MAX_RADIUS+2 line cells, each a line bank with one write and one read
// port; results leave in raster order once their window is in. An item
// that yields no result leaves the block ready for the next item. For one
// that yields a result the block accepts it, reads the center, makes
// 2*radius+1 column reads (all line cells read the same column at once)
// and gathers the last compare. The next item is taken while a finished
// result waits at the output. The sample ring is not cleared after reset.
module window_max_suppression #(
  parameter int MAX_WIDTH   = wms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = wms_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = wms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wms_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wms_pkg::out_item_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int SW     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int NLINES = 2 * MAX_RADIUS + 2;
  localparam int LW     = $clog2(NLINES);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int DW     = RW + 1;
  localparam int DEPTH  = MAX_WIDTH * (2 * MAX_RADIUS + 1);
  localparam int PW     = $clog2(DEPTH + 1);

  // configuration
  logic [10:0]        frame_width_r;
  logic [15:0]        frame_height_r;
  logic [2:0]         radius_r;
  logic signed [31:0] suppress_r;

  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [RW-1:0] r_eff;

  // position and fill state
  logic [CW-1:0] in_col_r,  in_col_nxt;
  logic [15:0]   in_row_r,  in_row_nxt;
  logic [LW-1:0] in_line_r, in_line_nxt;
  logic [CW-1:0] out_col_r,  out_col_nxt;
  logic [15:0]   out_row_r,  out_row_nxt;
  logic [LW-1:0] out_line_r, out_line_nxt;
  logic [PW-1:0] pending_r,  pending_nxt, pending_inc;

  wms_pkg::state_t state_r, state_nxt;

  logic signed [DW-1:0]  dc_r, dc_nxt, r_signed;
  logic signed [CW+1:0]  cc;
  logic                  cc_ok;
  logic                  col_ok_r, col_ok_nxt;
  logic                  tag_center_r, tag_center_nxt;
  logic signed [SW-1:0]  center_r, center_nxt;
  logic                  supp_r, supp_nxt, supp_all;
  logic                  out_valid_r, out_valid_nxt;
  wms_pkg::out_item_t    out_r, out_nxt;

  logic          in_fire, pix_fire, load_out, rd_en, emit;
  logic [CW-1:0] rd_addr;
  logic [RW-1:0] rem_r, rem_c;
  logic [RW+WW-1:0] prod;
  logic [31:0]   req;

  logic [NLINES-1:0]    row_en, is_center;
  wms_pkg::cell_ctl_t   ctl [NLINES];
  logic                 greater_chain [NLINES+1];
  logic signed [SW-1:0] center_chain  [NLINES+1];

  // effective sizes
  always_comb begin
    if (frame_width_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff = (frame_height_r == 16'd0) ? 16'd1 : frame_height_r;
    r_eff = (32'(radius_r) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= wms_pkg::FRAME_WIDTH_RST;
      frame_height_r <= wms_pkg::FRAME_HEIGHT_RST;
      radius_r       <= wms_pkg::RADIUS_RST;
      suppress_r     <= wms_pkg::SUPPRESS_RST;
    end else if (cfg_wr_en) begin
      case (wms_pkg::reg_index_t'(cfg_index))
        wms_pkg::REG_FRAME_WIDTH:    frame_width_r  <= cfg_wdata[10:0];
        wms_pkg::REG_FRAME_HEIGHT:   frame_height_r <= cfg_wdata[15:0];
        wms_pkg::REG_RADIUS:         radius_r       <= cfg_wdata[2:0];
        wms_pkg::REG_SUPPRESS_VALUE: suppress_r     <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // readiness of the next result position
  always_comb begin
    if (32'(out_row_r) + 32'(r_eff) <= 32'(h_eff) - 32'd1) begin
      rem_r = r_eff;
    end else if (32'(out_row_r) < 32'(h_eff) - 32'd1) begin
      rem_r = RW'(32'(h_eff) - 32'd1 - 32'(out_row_r));
    end else begin
      rem_r = '0;
    end
    if (32'(out_col_r) + 32'(r_eff) <= 32'(w_eff) - 32'd1) begin
      rem_c = r_eff;
    end else if (32'(out_col_r) < 32'(w_eff) - 32'd1) begin
      rem_c = RW'(32'(w_eff) - 32'd1 - 32'(out_col_r));
    end else begin
      rem_c = '0;
    end
    prod = (RW+WW)'(rem_r) * (RW+WW)'(w_eff);
    req  = 32'(prod) + 32'(rem_c);
  end

  assign in_fire     = in_valid && in_ready;
  assign pix_fire    = in_fire && !in_data.kind;
  assign pending_inc = (32'(pending_r) == 32'(DEPTH)) ? pending_r : pending_r + PW'(1);
  assign emit        = (pix_fire ? (pending_inc != '0) : (pending_r != '0)) &&
                       ((pix_fire ? 32'(pending_inc) : 32'(pending_r)) - 32'd1 >= req);

  assign r_signed = $signed({1'b0, r_eff});
  assign cc       = $signed({2'b00, out_col_r}) + (CW+2)'(dc_r);
  assign cc_ok    = (cc >= 0) && (cc < $signed((CW+2)'(w_eff)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wms_pkg::ST_IDLE: begin
        if (in_fire && emit) begin
          state_nxt = wms_pkg::ST_CENTER;
        end
      end
      wms_pkg::ST_CENTER: state_nxt = wms_pkg::ST_SCAN;
      wms_pkg::ST_SCAN: begin
        if (dc_r == r_signed) begin
          state_nxt = wms_pkg::ST_LAST;
        end
      end
      wms_pkg::ST_LAST: begin
        if (load_out) begin
          state_nxt = wms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wms_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready       = (state_r == wms_pkg::ST_IDLE);
    rd_en          = (state_r == wms_pkg::ST_CENTER) || (state_r == wms_pkg::ST_SCAN);
    rd_addr        = (state_r == wms_pkg::ST_CENTER) ? out_col_r : cc[CW-1:0];
    col_ok_nxt     = (state_r == wms_pkg::ST_SCAN) && cc_ok;
    tag_center_nxt = (state_r == wms_pkg::ST_CENTER);
    load_out       = (state_r == wms_pkg::ST_LAST) && (!out_valid_r || out_ready);
    dc_nxt         = (state_r == wms_pkg::ST_CENTER) ? -r_signed :
                     ((state_r == wms_pkg::ST_SCAN) ? dc_r + DW'(1) : dc_r);
  end

  // input position
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_line_nxt = in_line_r;
    if (pix_fire) begin
      if (32'(in_col_r) + 32'd1 >= 32'(w_eff)) begin
        in_col_nxt  = '0;
        in_row_nxt  = (32'(in_row_r) + 32'd1 >= 32'(h_eff)) ? 16'd0 : in_row_r + 16'd1;
        in_line_nxt = (32'(in_line_r) == NLINES - 1) ? '0 : in_line_r + LW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
  end

  // result assembly and output position
  always_comb begin
    supp_all     = supp_r | greater_chain[NLINES];
    supp_nxt     = (state_r == wms_pkg::ST_CENTER) ? 1'b0 : supp_all;
    center_nxt   = tag_center_r ? center_chain[NLINES] : center_r;
    out_nxt      = out_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_line_nxt = out_line_r;
    pending_nxt  = pix_fire ? pending_inc : pending_r;
    if (load_out) begin
      out_nxt.result_value   = supp_all ? suppress_r : 32'(center_r);
      out_nxt.out_col        = 10'(out_col_r);
      out_nxt.out_row        = out_row_r;
      out_nxt.was_suppressed = supp_all;
      out_nxt.frame_last     = (32'(out_row_r) == 32'(h_eff) - 32'd1) &&
                               (32'(out_col_r) == 32'(w_eff) - 32'd1);
      pending_nxt            = pending_r - PW'(1);
      if (32'(out_col_r) + 32'd1 >= 32'(w_eff)) begin
        out_col_nxt  = '0;
        out_row_nxt  = (32'(out_row_r) + 32'd1 >= 32'(h_eff)) ? 16'd0 : out_row_r + 16'd1;
        out_line_nxt = (32'(out_line_r) == NLINES - 1) ? '0 : out_line_r + LW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // which line cells hold window rows of the current result
  always_comb begin
    int diff;
    int d;
    for (int i = 0; i < NLINES; i++) begin
      diff = i + NLINES - int'(out_line_r);
      if (diff >= NLINES) begin
        diff = diff - NLINES;
      end
      d = (diff <= MAX_RADIUS) ? diff : diff - NLINES;
      row_en[i]    = (d <= int'(r_eff)) && (-d <= int'(r_eff)) &&
                     (int'(out_row_r) + d >= 0) && (int'(out_row_r) + d < int'(h_eff));
      is_center[i] = (diff == 0);
    end
  end

  assign greater_chain[0] = 1'b0;
  assign center_chain[0]  = '0;

  for (genvar g = 0; g < NLINES; g++) begin : g_cell
    always_comb begin
      ctl[g].wr_en     = pix_fire && (32'(in_line_r) == g);
      ctl[g].rd_en     = rd_en;
      ctl[g].row_en    = row_en[g];
      ctl[g].is_center = is_center[g];
    end

    wms_cell #(
      .SW        (SW),
      .MAX_WIDTH (MAX_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl[g]),
      .wr_addr     (in_col_r),
      .wr_data     (SW'(in_data.response)),
      .rd_addr     (rd_addr),
      .col_ok      (col_ok_r),
      .center      (center_r),
      .greater_in  (greater_chain[g]),
      .center_in   (center_chain[g]),
      .greater_out (greater_chain[g+1]),
      .center_out  (center_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wms_pkg::ST_IDLE;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_line_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_line_r   <= '0;
      pending_r    <= '0;
      col_ok_r     <= 1'b0;
      tag_center_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_line_r    <= in_line_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_line_r   <= out_line_nxt;
      pending_r    <= pending_nxt;
      col_ok_r     <= col_ok_nxt;
      tag_center_r <= tag_center_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dc_r     <= dc_nxt;
    center_r <= center_nxt;
    supp_r   <= supp_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pending_r) <= 32'(DEPTH))
    else $error("pending count beyond ring depth");

  a_load_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> pending_r != '0)
    else $error("result loaded with no pending sample");

  a_valid_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wms_pkg::ST_LAST))
    else $error("result raised outside the gather step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wms_pkg::ST_SCAN) |=> !$changed(in_col_r))
    else $error("input position moved during a window scan");
`endif

endmodule
